// File: src/brfs_pkg.sv
// ----------------------------------------------------------------------------
// brfs_pkg
// Shared types and codes for the byte ring fifo with search
// ----------------------------------------------------------------------------
package brfs_pkg;

   localparam int FUNC_W = 2;
   localparam int BYTE_W = 8;

   localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [FUNC_W-1:0] func_type;

endpackage

// File: src/brfs_req_if.sv
// ----------------------------------------------------------------------------
// brfs_req_if
// Request channel: one operation per beat (push, pop or search)
// ----------------------------------------------------------------------------
interface brfs_req_if #(
   parameter int LOG2_DEPTH = 10
);
   logic                    valid;
   logic                    ready;
   brfs_pkg::func_type      func;
   brfs_pkg::byte_type      data_in;
   logic [LOG2_DEPTH:0]     search_limit;

   modport source (output valid, output func, output data_in, output search_limit,
                   input ready);
   modport sink   (input valid, input func, input data_in, input search_limit,
                   output ready);
endinterface

// File: src/brfs_rsp_if.sv
// ----------------------------------------------------------------------------
// brfs_rsp_if
// Response channel: one result beat for every request beat
// ----------------------------------------------------------------------------
interface brfs_rsp_if #(
   parameter int LOG2_DEPTH = 10
);
   logic                    valid;
   logic                    ready;
   logic                    ok;
   brfs_pkg::byte_type      data_out;
   logic [LOG2_DEPTH-1:0]   position;
   logic [LOG2_DEPTH:0]     fill_level;

   modport source (output valid, output ok, output data_out, output position,
                   output fill_level, input ready);
   modport sink   (input valid, input ok, input data_out, input position,
                   input fill_level, output ready);
endinterface

// File: src/byte_ring_fifo_with_search.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search
// Byte ring buffer of 2^LOG2_DEPTH entries with push, pop and byte search
// ----------------------------------------------------------------------------
// Usage: each req_bus beat carries one operation (push, pop or search) and
// produces exactly one rsp_bus beat carrying ok, the popped byte, the match
// offset and the fill level after the operation.
// The bytes live in one synchronous ram with a registered read; read and write
// pointers are one bit wider than the address so full and empty differ.
// One operation is in flight at a time. Steps from accept to result valid:
//   push, unused code, empty pop, search over nothing : registered at accept
//   pop of a held byte : ram read at accept, then its read data is registered
//   search : offset 0 read at accept, one ram read per scanned byte; the
//     result is registered on a match at offset k, or after span bytes with
//     no match, where span is min(search_limit, fill level)
// Pushes are taken one per cycle while the receiver keeps up; a pop holds off
// new requests until its byte is read. The result sits in an output register;
// when the receiver stalls, req_bus.ready stays low until that beat is taken.
// Reset (synchronous) empties the ring; the ram contents are not cleared,
// they are only read after being written.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search #(
   parameter int LOG2_DEPTH = 10
) (
   input  logic     clock,
   input  logic     reset,
   brfs_req_if.sink   req_bus,
   brfs_rsp_if.source rsp_bus
);

   localparam int ADDR_W = LOG2_DEPTH;
   localparam int LVL_W  = LOG2_DEPTH + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_POP_WAIT, ST_SEARCH} state_type;

   state_type           state_ff, state_in;
   logic [LVL_W-1:0]    wp_ff, wp_in;
   logic [LVL_W-1:0]    rp_ff, rp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                ok_ff, ok_in;
   brfs_pkg::byte_type  dout_ff, dout_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [LVL_W-1:0]    fill_ff, fill_in;
   brfs_pkg::byte_type  value_ff, value_in;
   logic [LVL_W-1:0]    span_ff, span_in;
   logic [ADDR_W-1:0]   k_ff, k_in;

   logic                req_ready;
   logic                accept;
   logic [LVL_W-1:0]    level;
   logic [LVL_W-1:0]    span_new;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   brfs_pkg::byte_type  wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   brfs_pkg::byte_type  rd_data;

   brfs_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (brfs_pkg::BYTE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign level     = wp_ff - rp_ff;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept    = req_bus.valid && req_ready;
   assign span_new  = (req_bus.search_limit < level) ? req_bus.search_limit : level;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ok_in        = ok_ff;
      dout_in      = dout_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      value_in     = value_ff;
      span_in      = span_ff;
      k_in         = k_ff;
      wr_en        = 1'b0;
      wr_addr      = wp_ff[ADDR_W-1:0];
      wr_data      = req_bus.data_in;
      rd_en        = 1'b0;
      rd_addr      = rp_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ok_in        = 1'b0;
               dout_in      = '0;
               pos_in       = '0;
               rsp_valid_in = 1'b1;
               case (req_bus.func)
                  brfs_pkg::FUNC_PUSH: begin
                     // msb of the level set means the ring is full
                     if (!level[ADDR_W]) begin
                        wr_en = 1'b1;
                        wp_in = wp_ff + LVL_W'(1);
                        ok_in = 1'b1;
                     end
                  end
                  brfs_pkg::FUNC_POP: begin
                     if (level != '0) begin
                        rd_en        = 1'b1;
                        rp_in        = rp_ff + LVL_W'(1);
                        rsp_valid_in = 1'b0;
                        state_in     = ST_POP_WAIT;
                     end
                  end
                  brfs_pkg::FUNC_SEARCH: begin
                     value_in = req_bus.data_in;
                     span_in  = span_new;
                     k_in     = '0;
                     if (span_new != '0) begin
                        rd_en        = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
               fill_in = wp_in - rp_in;
            end
         end
         ST_POP_WAIT: begin
            ok_in        = 1'b1;
            dout_in      = rd_data;
            pos_in       = '0;
            fill_in      = level;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SEARCH: begin
            // rd_data holds offset k; fetch offset k+1 in the same cycle
            rd_en   = 1'b1;
            rd_addr = rp_ff[ADDR_W-1:0] + k_ff + ADDR_W'(1);
            if (rd_data == value_ff) begin
               ok_in        = 1'b1;
               dout_in      = '0;
               pos_in       = k_ff;
               fill_in      = level;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (LVL_W'(k_ff) + LVL_W'(1) == span_ff) begin
               ok_in        = 1'b0;
               dout_in      = '0;
               pos_in       = '0;
               fill_in      = level;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               k_in = k_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff    <= ok_in;
      dout_ff  <= dout_in;
      pos_ff   <= pos_in;
      fill_ff  <= fill_in;
      value_ff <= value_in;
      span_ff  <= span_in;
      k_ff     <= k_in;
   end

   assign req_bus.ready      = req_ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.ok         = ok_ff;
   assign rsp_bus.data_out   = dout_ff;
   assign rsp_bus.position   = pos_ff;
   assign rsp_bus.fill_level = fill_ff;

   // busy states only run with the result register free
   a_busy_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result beat pending while an operation is in flight");

   // the ring never holds more than its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= LVL_W'(1 << ADDR_W))
      else $error("fill level above ring depth");

   // scan offset stays inside the span being searched
   a_scan_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (LVL_W'(k_ff) < span_ff))
      else $error("search offset beyond span");

   // a stored push advances the write pointer by one
   a_push_advance: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (wp_ff == $past(wp_ff) + LVL_W'(1)))
      else $error("write pointer did not advance on push");

endmodule

// File: src/brfs_ram.sv
// ----------------------------------------------------------------------------
// brfs_ram
// Simple dual-port byte store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module brfs_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
